// ----- design/string_key_bucket_hash_top_assert.svh -----
// assertion macros used by the checker file of the bucket hash block
`ifndef STRING_KEY_BUCKET_HASH_TOP_ASSERT_SVH
`define STRING_KEY_BUCKET_HASH_TOP_ASSERT_SVH

// property checked on every clock edge while out of reset
`define SKBH_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("skbh assertion failed");

// signal must hold its value in the cycle after cond
`define SKBH_ASSERT_HOLD(label, cond, sig) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> $stable(sig)) else $error("skbh signal not held");

`endif

// ----- design/skbh_pkg.sv -----
// types, constants and the permutation table of the bucket hash block
package skbh_pkg;

  localparam int unsigned HashW      = 32;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned BucketW    = 16;
  localparam int unsigned CfgW       = 5;
  localparam int unsigned HashShift  = 4;
  localparam int unsigned FoldPos    = 16;
  localparam int unsigned FoldShHi   = 16;
  localparam int unsigned FoldShLo   = 5;

  localparam logic [CfgW-1:0]  BucketBitsMin   = 5'd4;
  localparam logic [CfgW-1:0]  BucketBitsMax   = 5'd16;
  localparam logic [BucketW-1:0] BucketMaskRst = 16'h000f;
  localparam logic [HashW-1:0] FoldMask        = 32'h0000_000f << FoldPos;

  // control handed from the input stage to the hash core
  typedef struct packed {
    logic go;
    logic last;
  } step_ctrl_t;

  localparam logic [ByteW-1:0] PermTab [256] = '{
    8'd1,   8'd14,  8'd110, 8'd25,  8'd97,  8'd174, 8'd132, 8'd119,
    8'd138, 8'd170, 8'd125, 8'd118, 8'd27,  8'd233, 8'd140, 8'd51,
    8'd87,  8'd197, 8'd177, 8'd107, 8'd234, 8'd169, 8'd56,  8'd68,
    8'd30,  8'd7,   8'd173, 8'd73,  8'd188, 8'd40,  8'd36,  8'd65,
    8'd49,  8'd213, 8'd104, 8'd190, 8'd57,  8'd211, 8'd148, 8'd223,
    8'd48,  8'd115, 8'd15,  8'd2,   8'd67,  8'd186, 8'd210, 8'd28,
    8'd12,  8'd181, 8'd103, 8'd70,  8'd22,  8'd58,  8'd75,  8'd78,
    8'd183, 8'd167, 8'd238, 8'd157, 8'd124, 8'd147, 8'd172, 8'd144,
    8'd176, 8'd161, 8'd141, 8'd86,  8'd60,  8'd66,  8'd128, 8'd83,
    8'd156, 8'd241, 8'd79,  8'd46,  8'd168, 8'd198, 8'd41,  8'd254,
    8'd178, 8'd85,  8'd253, 8'd237, 8'd250, 8'd154, 8'd133, 8'd88,
    8'd35,  8'd206, 8'd95,  8'd116, 8'd252, 8'd192, 8'd54,  8'd221,
    8'd102, 8'd218, 8'd255, 8'd240, 8'd82,  8'd106, 8'd158, 8'd201,
    8'd61,  8'd3,   8'd89,  8'd9,   8'd42,  8'd155, 8'd159, 8'd93,
    8'd166, 8'd80,  8'd50,  8'd34,  8'd175, 8'd195, 8'd100, 8'd99,
    8'd26,  8'd150, 8'd16,  8'd145, 8'd4,   8'd33,  8'd8,   8'd189,
    8'd121, 8'd64,  8'd77,  8'd72,  8'd208, 8'd245, 8'd130, 8'd122,
    8'd143, 8'd55,  8'd105, 8'd134, 8'd29,  8'd164, 8'd185, 8'd194,
    8'd193, 8'd239, 8'd101, 8'd242, 8'd5,   8'd171, 8'd126, 8'd11,
    8'd74,  8'd59,  8'd137, 8'd228, 8'd108, 8'd191, 8'd232, 8'd139,
    8'd6,   8'd24,  8'd81,  8'd20,  8'd127, 8'd17,  8'd91,  8'd92,
    8'd251, 8'd151, 8'd225, 8'd207, 8'd21,  8'd98,  8'd113, 8'd112,
    8'd84,  8'd226, 8'd18,  8'd214, 8'd199, 8'd187, 8'd13,  8'd32,
    8'd94,  8'd220, 8'd224, 8'd212, 8'd247, 8'd204, 8'd196, 8'd43,
    8'd249, 8'd236, 8'd45,  8'd244, 8'd111, 8'd182, 8'd153, 8'd136,
    8'd129, 8'd90,  8'd217, 8'd202, 8'd19,  8'd165, 8'd231, 8'd71,
    8'd230, 8'd142, 8'd96,  8'd227, 8'd62,  8'd179, 8'd246, 8'd114,
    8'd162, 8'd53,  8'd160, 8'd215, 8'd205, 8'd180, 8'd47,  8'd109,
    8'd44,  8'd38,  8'd31,  8'd149, 8'd135, 8'd0,   8'd216, 8'd52,
    8'd63,  8'd23,  8'd37,  8'd69,  8'd39,  8'd117, 8'd146, 8'd184,
    8'd163, 8'd200, 8'd222, 8'd235, 8'd248, 8'd243, 8'd219, 8'd10,
    8'd152, 8'd131, 8'd123, 8'd229, 8'd203, 8'd76,  8'd120, 8'd209
  };

  // one hash step: shift, add table entry, fold bits 16..19 back down
  function automatic logic [HashW-1:0] hash_step(input logic [HashW-1:0] h_in,
                                                 input logic [ByteW-1:0] b);
    logic [HashW-1:0] h;
    logic [HashW-1:0] g;
    h = (h_in << HashShift) + {{(HashW-ByteW){1'b0}}, PermTab[b]};
    g = h & FoldMask;
    return h ^ (g >> FoldShHi) ^ (g >> FoldShLo);
  endfunction

  // clamp the slot count and build the bucket mask
  function automatic logic [BucketW-1:0] bucket_mask(input logic [CfgW-1:0] bits);
    logic [CfgW-1:0] nb;
    logic [HashW-1:0] m;
    nb = bits;
    if (nb < BucketBitsMin) begin
      nb = BucketBitsMin;
    end
    if (nb > BucketBitsMax) begin
      nb = BucketBitsMax;
    end
    m = (32'd1 << nb) - 32'd1;
    return m[BucketW-1:0];
  endfunction

endpackage

// ----- design/skbh_if.sv -----
// valid/ready channel interfaces of the bucket hash block

// key byte request channel
interface skbh_in_if import skbh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] key_byte;
  logic             last_byte;

  modport source (output valid, key_byte, last_byte, input ready);
  modport sink   (input valid, key_byte, last_byte, output ready);
endinterface

// hash result channel
interface skbh_out_if import skbh_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [HashW-1:0]   hash_value;
  logic [BucketW-1:0] bucket_index;

  modport source (output valid, hash_value, bucket_index, input ready);
  modport sink   (input valid, hash_value, bucket_index, output ready);
endinterface

// bucket_bits register write channel
interface skbh_cfg_if import skbh_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CfgW-1:0] bucket_bits;

  modport source (output valid, bucket_bits, input ready);
  modport sink   (input valid, bucket_bits, output ready);
endinterface

// ----- design/skbh_core.sv -----
// running hash register and one-byte hash step
module skbh_core import skbh_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  step_ctrl_t       ctrl_i,
  input  logic [ByteW-1:0] key_byte_i,
  output logic [HashW-1:0] hash_o
);

  logic [HashW-1:0] run_hash_q;
  logic [HashW-1:0] run_hash_d;

  // hash of the key so far plus this byte
  assign hash_o = hash_step(run_hash_q, key_byte_i);

  // keep the partial hash, restart after the last byte
  always_comb begin
    run_hash_d = run_hash_q;
    if (ctrl_i.go) begin
      run_hash_d = ctrl_i.last ? '0 : hash_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_hash_q <= '0;
    end else begin
      run_hash_q <= run_hash_d;
    end
  end

endmodule

// ----- design/string_key_bucket_hash_top.sv -----
// top level of the string key bucket hash block
//
//  channel  dir  payload                        handshake
//  in_i     in   key_byte[7:0], last_byte       valid/ready
//  out_o    out  hash_value[31:0], bucket_index valid/ready
//  cfg_i    in   bucket_bits[4:0]               valid/ready, ready always high
//
// one key byte per cycle while a stalled result does not hold a last byte back;
// a byte passes an input register, then the hash step (table lookup, shift,
// add, fold) writes the result register.
// reset clears the running hash and sets bucket_bits to 4.
// a stalled result holds a last byte and the bytes behind it; others flow on.
module string_key_bucket_hash_top import skbh_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  skbh_in_if.sink    in_i,
  skbh_out_if.source out_o,
  skbh_cfg_if.sink   cfg_i
);

  logic               in_vld_q;
  logic [ByteW-1:0]   in_byte_q;
  logic               in_last_q;
  logic               out_vld_q;
  logic [HashW-1:0]   out_hash_q;
  logic [BucketW-1:0] out_bkt_q;
  logic [BucketW-1:0] mask_q;
  logic               out_free;
  logic               in_take;
  step_ctrl_t         step;
  logic [HashW-1:0]   hash_new;

  // flow control between input register and result register
  assign out_free   = !out_vld_q || out_o.ready;
  assign step.go    = in_vld_q && (!in_last_q || out_free);
  assign step.last  = in_last_q;
  assign in_i.ready = !in_vld_q || step.go;
  assign in_take    = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= in_i.key_byte;
      in_last_q <= in_i.last_byte;
    end
  end

  // hash step
  skbh_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (step),
    .key_byte_i (in_byte_q),
    .hash_o     (hash_new)
  );

  // bucket mask, clamped at write time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= BucketMaskRst;
    end else if (cfg_i.valid) begin
      mask_q <= bucket_mask(cfg_i.bucket_bits);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step.go && step.last) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step.go && step.last) begin
      out_hash_q <= hash_new;
      out_bkt_q  <= hash_new[BucketW-1:0] & mask_q;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.hash_value   = out_hash_q;
  assign out_o.bucket_index = out_bkt_q;

endmodule

// ----- design/skbh_checker.sv -----
// port-level checker of the bucket hash block and its bind
`include "string_key_bucket_hash_top_assert.svh"

module skbh_checker import skbh_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [HashW-1:0]   hash_value,
  input logic [BucketW-1:0] bucket_index
);

  // a stalled result keeps its hash
  `SKBH_ASSERT_HOLD(a_out_hash_hold, out_valid && !out_ready, hash_value)

  // bucket index only keeps bits of the hash
  `SKBH_ASSERT(a_bkt_subset, !out_valid || ((bucket_index & ~hash_value[BucketW-1:0]) == '0))

  // at least four bucket bits always survive the mask
  `SKBH_ASSERT(a_bkt_low_bits, !out_valid || (bucket_index[3:0] == hash_value[3:0]))

  // register port never stalls
  `SKBH_ASSERT(a_cfg_ready, cfg_ready)

endmodule

bind string_key_bucket_hash_top skbh_checker u_skbh_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_ready    (cfg_i.ready),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .hash_value   (out_o.hash_value),
  .bucket_index (out_o.bucket_index)
);

// ----- bench/tb.sv -----
// self-checking testbench of the string key bucket hash block
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import skbh_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  typedef struct {
    logic [HashW-1:0]   hash;
    logic [BucketW-1:0] bucket;
  } key_hash_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  skbh_in_if  in_if ();
  skbh_out_if out_if ();
  skbh_cfg_if cfg_if ();

  string_key_bucket_hash_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // predictor state and the hashes still owed by the block
  logic [HashW-1:0] partial_hash = '0;
  logic [CfgW-1:0]  slot_bits_cfg = 5'd4;
  key_hash_t        expected_hashes [$];
  key_hash_t        want;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned keys_sent = 0;
  int unsigned hashes_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned cycle_count = 0;

  // clock
  always #6 clk_i = ~clk_i;

  // one key byte folded into the running hash
  function automatic logic [HashW-1:0] mix_key_byte(input logic [HashW-1:0] h,
                                                    input logic [ByteW-1:0] b);
    logic [HashW-1:0] s;
    logic [HashW-1:0] top;
    s = (h << 4) + {24'd0, PermTab[b]};
    top = s & 32'h000f_0000;
    return s ^ (top >> 16) ^ (top >> 5);
  endfunction

  // hash masked to the clamped slot count
  function automatic logic [BucketW-1:0] slot_of(input logic [HashW-1:0] h);
    int unsigned nb;
    logic [HashW-1:0] m;
    nb = slot_bits_cfg;
    if (nb < 4) begin
      nb = 4;
    end
    if (nb > 16) begin
      nb = 16;
    end
    m = (32'd1 << nb) - 32'd1;
    return h[BucketW-1:0] & m[BucketW-1:0];
  endfunction

  // key byte with a bias toward the extremes
  function automatic logic [ByteW-1:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return 8'h00;
    end else if (r == 1) begin
      return 8'hff;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // send one byte request and predict its effect once taken
  task automatic send_byte(input logic [ByteW-1:0] b, input logic lst);
    logic [HashW-1:0] nxt;
    key_hash_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.key_byte  <= b;
    in_if.last_byte <= lst;
    do @(posedge clk_i); while (!in_if.ready);
    bytes_sent++;
    nxt = mix_key_byte(partial_hash, b);
    if (lst) begin
      res.hash   = nxt;
      res.bucket = slot_of(nxt);
      expected_hashes.push_back(res);
      partial_hash = '0;
      keys_sent++;
    end else begin
      partial_hash = nxt;
    end
  endtask

  // random key of the given length
  task automatic send_key(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(pick_byte(), i == len - 1);
    end
  endtask

  // let every owed hash arrive, then let the pipeline settle
  task automatic drain_pending();
    in_if.valid <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // bucket_bits register write, only called with the block idle
  task automatic write_slot_bits(input logic [CfgW-1:0] v);
    cfg_if.valid       <= 1'b1;
    cfg_if.bucket_bits <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    slot_bits_cfg = v;
    cfg_writes++;
  endtask

  // single-byte keys under the reset slot count, zero byte included
  task automatic test_reset_slots();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'h01, 1'b1);
    drain_pending();
  endtask

  // long key that shifts bits off the top and exercises the fold
  task automatic test_long_key();
    for (int i = 0; i < 10; i++) begin
      send_byte(8'hff, 1'b0);
    end
    send_byte(8'h00, 1'b1);
    drain_pending();
  endtask

  // slot counts below, at and above the legal range
  task automatic test_slot_clamp();
    logic [CfgW-1:0] vals [6];
    vals = '{5'd0, 5'd3, 5'd4, 5'd16, 5'd17, 5'd31};
    foreach (vals[i]) begin
      write_slot_bits(vals[i]);
      send_byte(8'($urandom_range(0, 255)), 1'b1);
      drain_pending();
    end
  endtask

  // random keys under one idle pattern, slot count changed between chunks
  task automatic test_random_keys(input int unsigned s_pct, input int unsigned r_pct,
                                  input int unsigned n_bytes);
    int unsigned sent;
    int unsigned chunk_end;
    int unsigned len;
    logic [CfgW-1:0] v;
    sent = 0;
    chunk_end = 60;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    while (sent < n_bytes) begin
      if ($urandom_range(0, 19) == 0) begin
        len = $urandom_range(9, 40);
      end else begin
        len = $urandom_range(1, 8);
      end
      send_key(len);
      sent += len;
      if (sent >= chunk_end) begin
        drain_pending();
        case ($urandom_range(0, 5))
          0: v = 5'd0;
          1: v = 5'd31;
          2: v = 5'd4;
          3: v = 5'd16;
          default: v = 5'($urandom_range(0, 31));
        endcase
        write_slot_bits(v);
        chunk_end += 60;
      end
    end
    drain_pending();
  endtask

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_hashes.size() == 0) begin
          errors++;
          $display("%0t: unexpected result hash %h bucket %h", $time,
                   out_if.hash_value, out_if.bucket_index);
        end else begin
          want = expected_hashes.pop_front();
          hashes_checked++;
          if (out_if.hash_value !== want.hash) begin
            errors++;
            $display("%0t: hash_value expected %h actual %h", $time,
                     want.hash, out_if.hash_value);
          end
          if (out_if.bucket_index !== want.bucket) begin
            errors++;
            $display("%0t: bucket_index expected %h actual %h", $time,
                     want.bucket, out_if.bucket_index);
          end
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end else begin
      out_if.ready <= 1'b0;
    end
  end

  // run time limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("** string_key_bucket_hash_top: FAILED **");
      $finish;
    end
  end

  // test sequence
  initial begin
    in_if.valid        <= 1'b0;
    in_if.key_byte     <= '0;
    in_if.last_byte    <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.bucket_bits <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_slots();
    test_long_key();
    test_slot_clamp();
    test_random_keys(36, 53, 225);
    test_random_keys(53, 36, 225);
    test_random_keys(0, 0, 225);

    drain_pending();
    repeat (8) @(posedge clk_i);
    $display("run covered %0d key bytes in %0d keys, %0d hashes checked", bytes_sent,
             keys_sent, hashes_checked);
    $display("bucket_bits written %0d times, from 0 to 31, under three stall patterns",
             cfg_writes);
    if (errors == 0) begin
      $display("** string_key_bucket_hash_top: PASSED **");
    end else begin
      $display("** string_key_bucket_hash_top: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/skbh_pkg.sv
design/skbh_if.sv
design/skbh_core.sv
design/string_key_bucket_hash_top.sv
design/skbh_checker.sv
bench/tb.sv
